### src/kmeans_assign_update_pass_assert.svh
// Assertion macros used by the checker of this block.
// Both sample on clk and are switched off while rst is high.
`ifndef KMEANS_ASSIGN_UPDATE_PASS_ASSERT_SVH
`define KMEANS_ASSIGN_UPDATE_PASS_ASSERT_SVH

// Same-cycle implication
`define KMAP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define KMAP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/kmap_pkg.sv
package kmap_pkg;

  // Operation codes on s_tuser
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Result kinds on m_tuser
  localparam logic KIND_ASSIGN   = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_CLUSTERS  = 2'd0;
  localparam logic [1:0] REG_DIMS      = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // Bus widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 80;

  // Parameter defaults
  localparam int MAX_CLUSTERS_DEF = 8;
  localparam int MAX_DIMS_DEF     = 8;
  localparam int COUNT_BITS_DEF   = 20;

endpackage

### src/kmap_div.sv
module kmap_div #(
  parameter int NB = 37,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NB-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NB-1:0] quotient
);

  localparam int IW = $clog2(NB + 1);

  logic          busy;
  logic [IW-1:0] itr;
  logic [DW-1:0] rem;
  logic [NB-1:0] quo;
  logic [DW-1:0] dvs;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh  = {rem, quo[NB-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      itr  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        itr  <= IW'(NB);
      end else if (busy) begin
        itr <= itr - 1'b1;
        if (itr == IW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo <= {quo[NB-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

### src/kmeans_assign_update_pass.sv
// K-means Lloyd pass engine. Load centroid coordinates with load transactions,
// stream point coordinates one per transaction, and close a pass with an
// end-of-pass transaction. One item is worked at a time; s_tready is high only
// while the sequencer is idle. A load is written in the cycle it is accepted.
// A point coordinate steps through a centroid read, the shared multiplier and
// an accumulate for each cluster; the last coordinate of a point adds the sum
// update and the assignment result. End of pass is paced by the bit-serial
// divider (one quotient bit per cycle), run once for each coordinate of each
// used cluster; each centroid result also waits for m_tready. Sums are cleared
// by per-entry valid bits, so no clearing pass follows reset.
module kmeans_assign_update_pass #(
  parameter int MAX_CLUSTERS = kmap_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS     = kmap_pkg::MAX_DIMS_DEF,
  parameter int COUNT_BITS   = kmap_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // cfg
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_data,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cluster_index[2:0], coord_index[5:3], value[21:6], zero[23:22]
  input  logic [kmap_pkg::IN_TDATA_W-1:0]  s_tdata,
  // operation[1:0]
  input  logic [1:0]                       s_tuser,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // cluster[2:0], coord_out_index[5:3], coord_value[21:6], distance[56:22],
  // member_count[76:57], converged[77], count_overflow[78], zero[79]
  output logic [kmap_pkg::OUT_TDATA_W-1:0] m_tdata,
  // kind[0]
  output logic                             m_tuser,
  output logic                             m_tlast
);

  import kmap_pkg::*;

  localparam int CW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DWI   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = COUNT_BITS + 16;
  localparam int NB    = SUM_W + 1;

  // Sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] P_RD    = 5'd1;
  localparam logic [4:0] P_MUL   = 5'd2;
  localparam logic [4:0] P_ACC   = 5'd3;
  localparam logic [4:0] P_CNT   = 5'd4;
  localparam logic [4:0] S_RD    = 5'd5;
  localparam logic [4:0] S_WR    = 5'd6;
  localparam logic [4:0] P_EMIT  = 5'd7;
  localparam logic [4:0] E_THR   = 5'd8;
  localparam logic [4:0] E_INIT  = 5'd9;
  localparam logic [4:0] E_CL    = 5'd10;
  localparam logic [4:0] E_RD    = 5'd11;
  localparam logic [4:0] E_DIV   = 5'd12;
  localparam logic [4:0] E_WAIT  = 5'd13;
  localparam logic [4:0] E_SQ    = 5'd14;
  localparam logic [4:0] E_SH    = 5'd15;
  localparam logic [4:0] E_MAX   = 5'd16;
  localparam logic [4:0] O_RD    = 5'd17;
  localparam logic [4:0] O_EMIT  = 5'd18;

  function automatic logic [AW-1:0] maddr(input logic [3:0] c, input logic [3:0] d);
    maddr = AW'(int'(c) * MAX_DIMS + int'(d));
  endfunction

  // Full signed difference needs 17 bits; its magnitude fits 16
  function automatic logic [16:0] absdiff(input logic [15:0] a, input logic [15:0] b);
    logic [17:0] df;
    df = {{2{a[15]}}, a} - {{2{b[15]}}, b};
    absdiff = df[17] ? 17'(18'd0 - df) : df[16:0];
  endfunction

  // Config
  logic [3:0]  k_raw, d_raw;
  logic [15:0] thr;
  logic [3:0]  kcl, dcl;

  // Input fields
  logic [1:0]  in_op;
  logic [2:0]  in_ci, in_di;
  logic [15:0] in_val;
  logic        acc;

  // Control and working registers
  logic [4:0]            state;
  logic [3:0]            c_cnt, d_cnt, best;
  logic [2:0]            pt_di;
  logic [15:0]           pt_val;
  logic [34:0]           bestd;
  logic [34:0]           pd [MAX_CLUSTERS];
  logic [COUNT_BITS-1:0] cnt [MAX_CLUSTERS];
  logic [15:0]           pb [MAX_DIMS];
  logic                  ovf;
  logic [DEPTH-1:0]      sum_vld;
  logic [31:0]           thr2;
  logic [35:0]           maxsh, shift;
  logic                  neg;
  logic [15:0]           nv;

  // Shared multiplier
  logic [16:0] mul_a, mul_b;
  logic [33:0] prod;

  // Memories
  logic [15:0]       cmem [DEPTH];
  logic              cm_we, cm_re;
  logic [AW-1:0]     cm_waddr, cm_raddr;
  logic [15:0]       cm_wdata, cent_q;
  logic [SUM_W-1:0]  smem [DEPTH];
  logic              sm_we, sm_re;
  logic [AW-1:0]     sm_addr;
  logic [SUM_W-1:0]  sm_wdata, sm_q, sum_eff, sum_mag;
  logic              sv_q;

  // Divider
  logic                  div_start, div_done;
  logic [NB-1:0]         div_dvd, div_q;
  logic [COUNT_BITS-1:0] cnt_c, cnt_best;

  // Output register
  logic        o_valid, o_kind, o_conv, o_ovf, o_last;
  logic [2:0]  o_cl, o_ci;
  logic [15:0] o_cv;
  logic [34:0] o_dist;
  logic [19:0] o_mc;
  logic        out_free, load_out;
  logic [31:0] mc_ext;

  // Accumulate helpers
  logic [35:0] newp;
  logic [34:0] satp;

  assign in_op  = s_tuser;
  assign in_ci  = s_tdata[2:0];
  assign in_di  = s_tdata[5:3];
  assign in_val = s_tdata[21:6];
  assign s_tready = (state == ST_IDLE);
  assign acc = s_tvalid && s_tready;

  // Clamp config to 1..MAX
  always_comb begin
    kcl = (k_raw == 4'd0) ? 4'd1 : (k_raw > 4'(MAX_CLUSTERS)) ? 4'(MAX_CLUSTERS) : k_raw;
    dcl = (d_raw == 4'd0) ? 4'd1 : (d_raw > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : d_raw;
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      k_raw <= 4'd2;
      d_raw <= 4'd2;
      thr   <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLUSTERS:  k_raw <= cfg_data[3:0];
        REG_DIMS:      d_raw <= cfg_data[3:0];
        REG_THRESHOLD: thr   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cnt_c    = cnt[c_cnt[CW-1:0]];
  assign cnt_best = cnt[best[CW-1:0]];

  // Multiplier operand select, result registered
  always_comb begin
    case (state)
      E_THR:   begin mul_a = {1'b0, thr}; mul_b = {1'b0, thr}; end
      E_SQ:    begin mul_a = absdiff(cent_q, nv); mul_b = absdiff(cent_q, nv); end
      default: begin mul_a = absdiff(pt_val, cent_q); mul_b = absdiff(pt_val, cent_q); end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Centroid memory port control
  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = maddr({1'b0, in_ci}, {1'b0, in_di});
    cm_wdata = in_val;
    if (state == E_SQ) begin
      cm_we    = 1'b1;
      cm_waddr = maddr(c_cnt, d_cnt);
      cm_wdata = nv;
    end else if (acc && in_op == OP_LOAD && {1'b0, in_ci} < 4'(MAX_CLUSTERS)
                 && {1'b0, in_di} < 4'(MAX_DIMS)) begin
      cm_we = 1'b1;
    end
    cm_re    = state inside {P_RD, E_RD, O_RD};
    cm_raddr = (state == P_RD) ? maddr(c_cnt, {1'b0, pt_di}) : maddr(c_cnt, d_cnt);
  end

  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_waddr] <= cm_wdata;
    if (cm_re) cent_q <= cmem[cm_raddr];
  end

  // Sum memory port control
  always_comb begin
    sm_re    = (state == S_RD) || (state == E_RD);
    sm_we    = (state == S_WR);
    sm_addr  = (state == E_RD) ? maddr(c_cnt, d_cnt) : maddr(best, d_cnt);
    sum_eff  = sv_q ? sm_q : '0;
    sm_wdata = sum_eff + {{(SUM_W-16){pb[d_cnt[DWI-1:0]][15]}}, pb[d_cnt[DWI-1:0]]};
    sum_mag  = sum_eff[SUM_W-1] ? ('0 - sum_eff) : sum_eff;
    div_dvd  = NB'(sum_mag) + NB'(cnt_c >> 1);
    div_start = (state == E_DIV);
  end

  always_ff @(posedge clk) begin
    if (sm_we) smem[sm_addr] <= sm_wdata;
    if (sm_re) begin
      sm_q <= smem[sm_addr];
      sv_q <= sum_vld[sm_addr];
    end
  end

  kmap_div #(.NB(NB), .DW(COUNT_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cnt_c),
    .done     (div_done),
    .quotient (div_q)
  );

  // Saturating distance accumulate
  always_comb begin
    newp = {1'b0, pd[c_cnt[CW-1:0]]} + {2'b00, prod};
    satp = newp[35] ? '1 : newp[34:0];
  end

  assign out_free = !o_valid || m_tready;
  assign load_out = ((state == P_EMIT) || (state == O_EMIT)) && out_free;

  // Point buffer
  always_ff @(posedge clk) begin
    if (acc && in_op == OP_POINT && {1'b0, in_di} < dcl) pb[in_di[DWI-1:0]] <= in_val;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      c_cnt   <= '0;
      d_cnt   <= '0;
      ovf     <= 1'b0;
      sum_vld <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        pd[i]  <= '0;
        cnt[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (in_op == OP_POINT && {1'b0, in_di} < dcl) begin
              pt_di  <= in_di;
              pt_val <= in_val;
              c_cnt  <= '0;
              state  <= P_RD;
            end else if (in_op == OP_END) begin
              state <= E_THR;
            end
          end
        end
        P_RD:  state <= P_MUL;
        P_MUL: state <= P_ACC;
        P_ACC: begin
          pd[c_cnt[CW-1:0]] <= satp;
          if (c_cnt == 4'd0 || satp < bestd) begin
            best  <= c_cnt;
            bestd <= satp;
          end
          if (c_cnt == kcl - 4'd1) begin
            state <= ({1'b0, pt_di} == dcl - 4'd1) ? P_CNT : ST_IDLE;
          end else begin
            c_cnt <= c_cnt + 4'd1;
            state <= P_RD;
          end
        end
        P_CNT: begin
          if (&cnt_best) begin
            ovf   <= 1'b1;
            state <= P_EMIT;
          end else begin
            cnt[best[CW-1:0]] <= cnt_best + 1'b1;
            d_cnt <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          sum_vld[sm_addr] <= 1'b1;
          if (d_cnt == dcl - 4'd1) begin
            state <= P_EMIT;
          end else begin
            d_cnt <= d_cnt + 4'd1;
            state <= S_RD;
          end
        end
        P_EMIT: begin
          if (out_free) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) pd[i] <= '0;
            state <= ST_IDLE;
          end
        end
        // End of pass: new means and shift
        E_THR: state <= E_INIT;
        E_INIT: begin
          thr2  <= prod[31:0];
          maxsh <= '0;
          c_cnt <= '0;
          state <= E_CL;
        end
        E_CL: begin
          if (cnt_c == '0) begin
            if (c_cnt == kcl - 4'd1) begin
              c_cnt <= '0;
              d_cnt <= '0;
              state <= O_RD;
            end else begin
              c_cnt <= c_cnt + 4'd1;
            end
          end else begin
            d_cnt <= '0;
            shift <= '0;
            state <= E_RD;
          end
        end
        E_RD: state <= E_DIV;
        E_DIV: begin
          neg   <= sum_eff[SUM_W-1];
          state <= E_WAIT;
        end
        E_WAIT: begin
          if (div_done) begin
            nv    <= neg ? (16'd0 - div_q[15:0]) : div_q[15:0];
            state <= E_SQ;
          end
        end
        E_SQ: state <= E_SH;
        E_SH: begin
          shift <= shift + 36'(prod);
          if (d_cnt == dcl - 4'd1) begin
            state <= E_MAX;
          end else begin
            d_cnt <= d_cnt + 4'd1;
            state <= E_RD;
          end
        end
        E_MAX: begin
          if (shift > maxsh) maxsh <= shift;
          if (c_cnt == kcl - 4'd1) begin
            c_cnt <= '0;
            d_cnt <= '0;
            state <= O_RD;
          end else begin
            c_cnt <= c_cnt + 4'd1;
            state <= E_CL;
          end
        end
        // Emit every coordinate of every configured cluster
        O_RD: state <= O_EMIT;
        O_EMIT: begin
          if (out_free) begin
            if (d_cnt == dcl - 4'd1) begin
              d_cnt <= '0;
              if (c_cnt == kcl - 4'd1) begin
                ovf     <= 1'b0;
                sum_vld <= '0;
                for (int i = 0; i < MAX_CLUSTERS; i++) begin
                  pd[i]  <= '0;
                  cnt[i] <= '0;
                end
                state <= ST_IDLE;
              end else begin
                c_cnt <= c_cnt + 4'd1;
                state <= O_RD;
              end
            end else begin
              d_cnt <= d_cnt + 4'd1;
              state <= O_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  assign mc_ext = 32'((state == P_EMIT) ? cnt_best : cnt_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_out) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_mc  <= mc_ext[19:0];
      o_ovf <= ovf;
      if (state == P_EMIT) begin
        o_kind <= KIND_ASSIGN;
        o_cl   <= best[2:0];
        o_ci   <= 3'd0;
        o_cv   <= 16'd0;
        o_dist <= bestd;
        o_conv <= 1'b0;
        o_last <= 1'b1;
      end else begin
        o_kind <= KIND_CENTROID;
        o_cl   <= c_cnt[2:0];
        o_ci   <= d_cnt[2:0];
        o_cv   <= cent_q;
        o_dist <= maxsh[34:0];
        o_conv <= maxsh < {4'd0, thr2};
        o_last <= (c_cnt == kcl - 4'd1) && (d_cnt == dcl - 4'd1);
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;
  assign m_tdata  = {1'b0, o_ovf, o_conv, o_mc, o_dist, o_cv, o_ci, o_cl};

endmodule

### src/kmap_checker.sv
`include "kmeans_assign_update_pass_assert.svh"

module kmap_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [1:0]                       s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [kmap_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tuser,
  input logic                             m_tlast
);

  import kmap_pkg::*;

  // Stalled result stays offered
  `KMAP_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // Assignment results are single-item runs with zero coordinate fields and converged clear
  `KMAP_ASSERT_IMP(a_assign_fmt, m_tvalid && m_tuser == KIND_ASSIGN,
                   m_tlast && m_tdata[21:3] == '0 && !m_tdata[77], "bad assignment result")

  // End of pass always occupies the sequencer
  `KMAP_ASSERT_NXT(a_end_busy, s_tvalid && s_tready && s_tuser == OP_END, !s_tready,
                   "ready right after end of pass")

  // A point or end result is never offered while the block sits idle with no output
  `KMAP_ASSERT_NXT(a_no_spurious, !m_tvalid && s_tready && !s_tvalid, !m_tvalid,
                   "result appeared without work")

endmodule

bind kmeans_assign_update_pass kmap_checker u_kmap_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
